/* hw/rtl/mssd_pkg.sv */
// Shared types, constants and glyph table for the sixteen-segment driver.
`timescale 1ns / 1ps

package mssd_pkg;

    // Field widths of the streams
    localparam int FUNC_W      = 2;
    localparam int POS_W       = 3;
    localparam int CHAR_W      = 8;
    localparam int NUM_W       = 32;
    localparam int IDX_OUT_W   = 3;
    localparam int EN_W        = 5;
    localparam int EN_FULL_W   = 8;
    localparam int SEG_W       = 16;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 24;

    // Function codes carried on s_tuser
    localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NUM  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    // Divide by ten through a reciprocal: q = (n * RECIP) >> RECIP_SHIFT, exact for 32 bits
    localparam logic [NUM_W-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

    // Glyph table covers codes 43 ('+') to 57 ('9')
    localparam logic [CHAR_W-1:0] FIRST_GLYPH = 8'd43;
    localparam int                GLYPH_COUNT = 15;
    localparam logic [CHAR_W-1:0] LAST_GLYPH  = 8'd57;

    localparam logic [SEG_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
        16'h4B00, // '+'
        16'h0000, // ','
        16'h0300, // '-'
        16'h0000, // '.'
        16'h3000, // '/'
        16'h00FF, // '0'
        16'h000C, // '1'
        16'h0377, // '2'
        16'h033F, // '3'
        16'h038C, // '4'
        16'h03BB, // '5'
        16'h03FB, // '6'
        16'h008F, // '7'
        16'h03FF, // '8'
        16'h03BF  // '9'
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIGIT,
        ST_TICK_WAIT
    } mssd_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_char;
        logic num_load;
        logic mul_en;
        logic digit_wr;
        logic tick_load;
    } mssd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic last_digit;
    } mssd_stat_t;

    // Map a character code to its segment pattern; codes without a glyph are blank
    function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] off;
        off = code - FIRST_GLYPH;
        if (code < FIRST_GLYPH || code > LAST_GLYPH) begin
            return '0;
        end
        return GLYPH_ROM[off[3:0]];
    endfunction

endpackage

/* hw/rtl/mssd_datapath.sv */
// Datapath: character store, scan index, decimal conversion and result register.
`timescale 1ns / 1ps

module mssd_datapath #(
    parameter int DIGIT_COUNT = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mssd_pkg::mssd_cmd_t          cmd,
    output mssd_pkg::mssd_stat_t         stat,
    input  logic [mssd_pkg::POS_W-1:0]   s_position,
    input  logic [mssd_pkg::CHAR_W-1:0]  s_char_code,
    input  logic [mssd_pkg::NUM_W-1:0]   s_number,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [mssd_pkg::IDX_OUT_W-1:0] m_digit_index,
    output logic [mssd_pkg::EN_W-1:0]    m_digit_enable_n,
    output logic [mssd_pkg::SEG_W-1:0]   m_segments
);
    import mssd_pkg::*;

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);
    localparam logic [EN_FULL_W-1:0] ALL_ONES = EN_FULL_W'((1 << DIGIT_COUNT) - 1);

    logic [CHAR_W-1:0]    char_store_reg [DIGIT_COUNT];
    logic [IDX_W-1:0]     scan_reg;
    logic [IDX_W-1:0]     scan_next;
    logic [IDX_W-1:0]     digit_cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     quot_reg;
    logic [2*NUM_W-1:0]   prod;
    logic [NUM_W-1:0]     quot_times_ten;
    logic [NUM_W-1:0]     rem_full;
    logic [CHAR_W-1:0]    digit_char;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [IDX_OUT_W-1:0] idx_out_reg;
    logic [EN_W-1:0]      enable_n_reg;
    logic [SEG_W-1:0]     seg_reg;
    logic [2:0]           en_shift;
    logic [EN_FULL_W-1:0] enable_full;

    // Reciprocal multiply gives the quotient; remainder is the low decimal digit
    assign prod           = num_reg * RECIP;
    assign quot_times_ten = (quot_reg << 3) + (quot_reg << 1);
    assign rem_full       = num_reg - quot_times_ten;
    assign digit_char     = ASCII_ZERO + {4'b0, rem_full[3:0]};

    // Scan index wraps after the last digit
    assign scan_next   = (scan_reg == LAST_IDX) ? '0 : scan_reg + 1'b1;
    assign en_shift    = 3'(DIGIT_COUNT - 1) - 3'(scan_reg);
    assign enable_full = ALL_ONES & ~(EN_FULL_W'(1) << en_shift);

    assign stat.out_free   = !m_valid_reg || m_tready;
    assign stat.last_digit = (digit_cnt_reg == '0);

    // Character store: direct writes and converted digits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                char_store_reg[i] <= '0;
            end
        end else if (cmd.wr_char) begin
            if ({1'b0, s_position} < 4'(DIGIT_COUNT)) begin
                char_store_reg[s_position[IDX_W-1:0]] <= s_char_code;
            end
        end else if (cmd.digit_wr) begin
            char_store_reg[digit_cnt_reg] <= digit_char;
        end
    end

    // Conversion registers: hold the running value, quotient and digit position
    always_ff @(posedge aclk) begin
        if (cmd.num_load) begin
            num_reg       <= s_number;
            digit_cnt_reg <= LAST_IDX;
        end else if (cmd.digit_wr) begin
            num_reg       <= quot_reg;
            digit_cnt_reg <= digit_cnt_reg - 1'b1;
        end
        if (cmd.mul_en) begin
            quot_reg <= {{(RECIP_SHIFT - NUM_W){1'b0}}, prod[2*NUM_W-1:RECIP_SHIFT]};
        end
    end

    // Advance the scan index on each tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
        end else if (cmd.tick_load) begin
            scan_reg <= scan_next;
        end
    end

    // Result register: load on a tick, drop once the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.tick_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_load) begin
            idx_out_reg  <= IDX_OUT_W'(scan_reg);
            enable_n_reg <= enable_full[EN_W-1:0];
            seg_reg      <= glyph_of(char_store_reg[scan_reg]);
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign m_digit_index    = idx_out_reg;
    assign m_digit_enable_n = enable_n_reg;
    assign m_segments       = seg_reg;

endmodule

/* hw/rtl/mssd_ctrl.sv */
// Controller state machine: accepts items and sequences number conversion and ticks.
`timescale 1ns / 1ps

module mssd_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic [mssd_pkg::FUNC_W-1:0]  s_func,
    output logic                         s_tready,
    input  mssd_pkg::mssd_stat_t         stat,
    output mssd_pkg::mssd_cmd_t          cmd
);
    import mssd_pkg::*;

    mssd_state_t state_reg;
    mssd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_func)
                        FUNC_NUM:  state_next = ST_MUL;
                        FUNC_TICK: state_next = stat.out_free ? ST_IDLE : ST_TICK_WAIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:       state_next = ST_DIGIT;
            ST_DIGIT:     state_next = stat.last_digit ? ST_IDLE : ST_MUL;
            ST_TICK_WAIT: state_next = stat.out_free ? ST_IDLE : ST_TICK_WAIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_func)
                        FUNC_CHAR: cmd.wr_char   = 1'b1;
                        FUNC_NUM:  cmd.num_load  = 1'b1;
                        FUNC_TICK: cmd.tick_load = stat.out_free;
                        default:   cmd         = '0;
                    endcase
                end
            end
            ST_MUL:       cmd.mul_en    = 1'b1;
            ST_DIGIT:     cmd.digit_wr  = 1'b1;
            ST_TICK_WAIT: cmd.tick_load = stat.out_free;
            default:      cmd           = '0;
        endcase
    end

endmodule

/* hw/rtl/multiplexed_sixteen_segment_driver.sv */
// Top level of the multiplexed sixteen-segment display driver.
// Usage:
//   The s_ channel carries one command per transfer, its kind on s_tuser:
//   character write (store a code at a position), number write (store the
//   low DIGIT_COUNT decimal digits of a value as ASCII) or scan tick.
//   Each tick returns one m_ transfer: the digit index, the active-low
//   enable lines and the segment pattern of the character at that index.
//   A character write completes on its transfer; a tick result is loaded
//   into the output register once that register is free. A number write
//   runs a multiply step (ST_MUL) then a digit step (ST_DIGIT) per decimal
//   digit: the shared reciprocal multiplier yields one quotient, one decimal
//   digit per pass; s_tready is low meanwhile. Function code 3 is accepted and ignored.
//   A finished result waits in the output register while writes go on; a
//   tick that finds it still held stalls s_tready until m_tready frees it.
//   Reset clears the character store to blank, the scan index to zero and
//   the output valid.
`timescale 1ns / 1ps

module multiplexed_sixteen_segment_driver #(
    parameter int DIGIT_COUNT = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // position [2:0], char_code [10:3], number [42:11], zero padding above
    input  logic [mssd_pkg::S_TDATA_W-1:0]   s_tdata,
    // func [1:0]
    input  logic [mssd_pkg::FUNC_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // digit_index [2:0], digit_enable_n [7:3], segments [23:8]
    output logic [mssd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mssd_pkg::*;

    mssd_cmd_t            cmd;
    mssd_stat_t           stat;
    logic [IDX_OUT_W-1:0] digit_index;
    logic [EN_W-1:0]      digit_enable_n;
    logic [SEG_W-1:0]     segments;

    mssd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mssd_datapath #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_position       (s_tdata[2:0]),
        .s_char_code      (s_tdata[10:3]),
        .s_number         (s_tdata[42:11]),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .m_digit_index    (digit_index),
        .m_digit_enable_n (digit_enable_n),
        .m_segments       (segments)
    );

    assign m_tdata = {segments, digit_enable_n, digit_index};

    // A tick loads the result register only when it is free
    a_tick_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick_load |-> (!m_tvalid || m_tready))
        else $error("tick result loaded over a pending result");

    // Presented digit index stays within the display
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[2:0]} < 4'(DIGIT_COUNT)))
        else $error("digit index out of range");

    // At most one enable line is driven low
    a_one_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(~m_tdata[7:3]) <= 1))
        else $error("more than one digit enabled");

    // A number write blocks the input while it converts
    a_num_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == FUNC_NUM) |=> !s_tready)
        else $error("input accepted during number conversion");

endmodule
